### design/ttv_pkg.sv
// Shared types, constants and helpers for the triangle tangent block.
`timescale 1ns / 1ps
`default_nettype none
package ttv_pkg;

    localparam int NORM_BIT = 29;
    localparam logic signed [32:0] DIFF_MAX = 33'sd2147483647;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] e0x;
        logic signed [31:0] e0y;
        logic signed [31:0] e0z;
        logic signed [31:0] e1x;
        logic signed [31:0] e1y;
        logic signed [31:0] e1z;
        logic signed [31:0] d0u;
        logic signed [31:0] d0v;
        logic signed [31:0] d1u;
        logic signed [31:0] d1v;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_CHECK,
        B_NORM,
        B_SQR,
        B_SQRT,
        B_DINIT,
        B_DIV,
        B_DSTORE,
        B_OUT
    } back_state_t;

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] hi,
                                                    input logic signed [31:0] lo);
        logic signed [32:0] d;
        d = 33'(hi) - 33'(lo);
        if (d > DIFF_MAX) begin
            return DIFF_MAX[31:0];
        end else if (d < -DIFF_MAX) begin
            return -(DIFF_MAX[31:0]);
        end
        return d[31:0];
    endfunction

endpackage
`default_nettype wire

### design/ttv_queue.sv
// Two-entry job queue between the corner front end and the tangent engine.
`timescale 1ns / 1ps
`default_nettype none
module ttv_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  ttv_pkg::job_t   push_data,
    output logic            full,
    output logic            pop_valid,
    input  wire             pop,
    output ttv_pkg::job_t   pop_data
);

    ttv_pkg::job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### design/ttv_front.sv
// Corner front end: holds two corners and forms clamped edge and texture deltas.
`timescale 1ns / 1ps
`default_nettype none
module ttv_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_valid,
    output logic              in_ready,
    input  ttv_pkg::vertex_t  in_vtx,
    output logic              push,
    output ttv_pkg::job_t     push_data,
    input  wire               queue_full
);

    logic [1:0]       corner_reg, corner_next;
    ttv_pkg::vertex_t a_reg, b_reg;
    logic             take, third;

    assign third    = (corner_reg >= 2'd2);
    assign in_ready = !third || !queue_full;
    assign take     = in_valid && in_ready;
    assign push     = take && third;

    always_comb begin
        push_data.e0x = ttv_pkg::sat_diff(b_reg.pos_x, a_reg.pos_x);
        push_data.e0y = ttv_pkg::sat_diff(b_reg.pos_y, a_reg.pos_y);
        push_data.e0z = ttv_pkg::sat_diff(b_reg.pos_z, a_reg.pos_z);
        push_data.e1x = ttv_pkg::sat_diff(in_vtx.pos_x, a_reg.pos_x);
        push_data.e1y = ttv_pkg::sat_diff(in_vtx.pos_y, a_reg.pos_y);
        push_data.e1z = ttv_pkg::sat_diff(in_vtx.pos_z, a_reg.pos_z);
        push_data.d0u = ttv_pkg::sat_diff(b_reg.tex_u, a_reg.tex_u);
        push_data.d0v = ttv_pkg::sat_diff(b_reg.tex_v, a_reg.tex_v);
        push_data.d1u = ttv_pkg::sat_diff(in_vtx.tex_u, a_reg.tex_u);
        push_data.d1v = ttv_pkg::sat_diff(in_vtx.tex_v, a_reg.tex_v);
        corner_next   = corner_reg;
        if (take) begin
            corner_next = third ? 2'd0 : corner_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && corner_reg == 2'd0) begin
            a_reg <= in_vtx;
        end
        if (take && corner_reg == 2'd1) begin
            b_reg <= in_vtx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= 2'd0;
        end else begin
            corner_reg <= corner_next;
        end
    end

endmodule
`default_nettype wire

### design/ttv_back.sv
// Tangent engine: shared multiplier, normalize, bit-serial root and divide.
`timescale 1ns / 1ps
`default_nettype none
module ttv_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              job_valid,
    output logic             job_pop,
    input  ttv_pkg::job_t    job,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [47:0]      m_tdata,
    output logic             m_tuser
);

    ttv_pkg::back_state_t state_reg, state_next;
    ttv_pkg::job_t        job_reg;
    logic [3:0]           cnt_reg;
    logic signed [63:0]   prod_reg;
    logic signed [63:0]   acc_reg [4];
    logic [62:0]          mag_reg [3];
    logic [61:0]          s_reg;
    logic [33:0]          rem_reg;
    logic [30:0]          root_reg;
    logic [4:0]           sq_cnt_reg;
    logic [44:0]          dnum_reg;
    logic [45:0]          dvs_reg;
    logic [15:0]          q_reg;
    logic [1:0]           comp_reg;
    logic [15:0]          tan_reg [3];
    logic                 deg_reg;
    logic                 valid_reg;
    logic [47:0]          tdata_reg;
    logic                 tuser_reg;

    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   mul_full;
    logic [62:0]          mx, m01;
    logic [63:0]          abs_t [3];
    logic [2:0]           k;
    logic [33:0]          remx, trial;
    logic                 out_free, degenerate_now;

    assign out_free = !valid_reg || m_tready;
    assign job_pop  = (state_reg == ttv_pkg::B_IDLE) && job_valid;
    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    always_comb begin
        mul_a = job_reg.d1v;
        mul_b = job_reg.e0x;
        if (state_reg == ttv_pkg::B_SQR) begin
            mul_a = {2'b00, mag_reg[cnt_reg[1:0]][29:0]};
            mul_b = {2'b00, mag_reg[cnt_reg[1:0]][29:0]};
        end else begin
            case (cnt_reg[2:0])
                3'd0: begin mul_a = job_reg.d1v; mul_b = job_reg.e0x; end
                3'd1: begin mul_a = job_reg.d0v; mul_b = job_reg.e1x; end
                3'd2: begin mul_a = job_reg.d1v; mul_b = job_reg.e0y; end
                3'd3: begin mul_a = job_reg.d0v; mul_b = job_reg.e1y; end
                3'd4: begin mul_a = job_reg.d1v; mul_b = job_reg.e0z; end
                3'd5: begin mul_a = job_reg.d0v; mul_b = job_reg.e1z; end
                3'd6: begin mul_a = job_reg.d0u; mul_b = job_reg.d1v; end
                default: begin mul_a = job_reg.d1u; mul_b = job_reg.d0v; end
            endcase
        end
        mul_full = 64'(mul_a) * 64'(mul_b);
        k        = cnt_reg[2:0] - 3'd1;
        for (int i = 0; i < 3; i++) begin
            abs_t[i] = acc_reg[i][63] ? -acc_reg[i] : acc_reg[i];
        end
        degenerate_now = (acc_reg[3] == 64'sd0) ||
                         (acc_reg[0] == 64'sd0 && acc_reg[1] == 64'sd0 &&
                          acc_reg[2] == 64'sd0);
        m01   = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        mx    = (m01 > mag_reg[2]) ? m01 : mag_reg[2];
        remx  = {rem_reg[31:0], s_reg[61:60]};
        trial = {1'b0, root_reg, 2'b01};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ttv_pkg::B_IDLE:   if (job_valid) state_next = ttv_pkg::B_MUL;
            ttv_pkg::B_MUL:    if (cnt_reg == 4'd8) state_next = ttv_pkg::B_CHECK;
            ttv_pkg::B_CHECK:  state_next = degenerate_now ? ttv_pkg::B_OUT : ttv_pkg::B_NORM;
            ttv_pkg::B_NORM: begin
                if (mx[62:30] == '0 && mx[ttv_pkg::NORM_BIT]) state_next = ttv_pkg::B_SQR;
            end
            ttv_pkg::B_SQR:    if (cnt_reg == 4'd3) state_next = ttv_pkg::B_SQRT;
            ttv_pkg::B_SQRT:   if (sq_cnt_reg == 5'd30) state_next = ttv_pkg::B_DINIT;
            ttv_pkg::B_DINIT:  state_next = ttv_pkg::B_DIV;
            ttv_pkg::B_DIV:    if (cnt_reg == 4'd15) state_next = ttv_pkg::B_DSTORE;
            ttv_pkg::B_DSTORE: state_next = (comp_reg == 2'd2) ? ttv_pkg::B_OUT : ttv_pkg::B_DINIT;
            ttv_pkg::B_OUT:    if (out_free) state_next = ttv_pkg::B_IDLE;
            default:           state_next = ttv_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ttv_pkg::B_IDLE: begin
                job_reg <= job;
                cnt_reg <= 4'd0;
            end
            ttv_pkg::B_MUL: begin
                prod_reg <= mul_full;
                cnt_reg  <= cnt_reg + 4'd1;
                if (cnt_reg != 4'd0) begin
                    if (!k[0]) begin
                        acc_reg[k[2:1]] <= prod_reg;
                    end else begin
                        acc_reg[k[2:1]] <= acc_reg[k[2:1]] - prod_reg;
                    end
                end
            end
            ttv_pkg::B_CHECK: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= abs_t[i][62:0];
                    tan_reg[i] <= 16'd0;
                end
                deg_reg <= degenerate_now;
                cnt_reg <= 4'd0;
                s_reg   <= '0;
            end
            ttv_pkg::B_NORM: begin
                if (mx[62:30] != '0) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end else if (!mx[ttv_pkg::NORM_BIT]) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            ttv_pkg::B_SQR: begin
                prod_reg <= mul_full;
                cnt_reg  <= cnt_reg + 4'd1;
                if (cnt_reg != 4'd0) begin
                    s_reg <= s_reg + prod_reg[61:0];
                end
                rem_reg    <= '0;
                root_reg   <= '0;
                sq_cnt_reg <= 5'd0;
            end
            ttv_pkg::B_SQRT: begin
                if (remx >= trial) begin
                    rem_reg  <= remx - trial;
                    root_reg <= {root_reg[29:0], 1'b1};
                end else begin
                    rem_reg  <= remx;
                    root_reg <= {root_reg[29:0], 1'b0};
                end
                s_reg      <= s_reg << 2;
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                comp_reg   <= 2'd0;
            end
            ttv_pkg::B_DINIT: begin
                dnum_reg <= {1'b0, mag_reg[comp_reg][29:0], 14'd0} + 45'(root_reg >> 1);
                dvs_reg  <= {root_reg, 15'd0};
                q_reg    <= 16'd0;
                cnt_reg  <= 4'd0;
            end
            ttv_pkg::B_DIV: begin
                if ({1'b0, dnum_reg} >= dvs_reg) begin
                    dnum_reg <= dnum_reg - dvs_reg[44:0];
                    q_reg    <= {q_reg[14:0], 1'b1};
                end else begin
                    q_reg    <= {q_reg[14:0], 1'b0};
                end
                dvs_reg <= dvs_reg >> 1;
                cnt_reg <= cnt_reg + 4'd1;
            end
            ttv_pkg::B_DSTORE: begin
                tan_reg[comp_reg] <= (acc_reg[comp_reg][63] ^ acc_reg[3][63]) ? -q_reg : q_reg;
                comp_reg          <= comp_reg + 2'd1;
            end
            ttv_pkg::B_OUT: begin
                if (out_free) begin
                    tdata_reg <= {tan_reg[2], tan_reg[1], tan_reg[0]};
                    tuser_reg <= deg_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttv_pkg::B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (valid_reg && m_tready) begin
                valid_reg <= 1'b0;
            end
            if (state_reg == ttv_pkg::B_OUT && out_free) begin
                valid_reg <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### design/triangle_tangent_vector.sv
// Top level of the per-triangle unit tangent block.
// Vertices stream in one per transfer; every third vertex closes a triangle and
// yields one unit tangent in Q2.14 (degenerate triangles give zeros and the flag).
// The front end takes a vertex each cycle while its two-entry job queue has room.
// The tangent engine works on one triangle at a time: it pops the job, forms the
// products on the shared 32x32 multiplier, classifies, normalizes (up to 33
// single-bit shifts), sums squares, takes the bit-serial square root, runs the
// three divides and loads the output register; degenerate triangles skip to it.
// Sustained rate is one triangle per engine pass.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_vector (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [159:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [47:0]  m_tdata,   // tan_x, tan_y, tan_z
    output logic         m_tuser    // degenerate
);

    ttv_pkg::vertex_t vtx;
    ttv_pkg::job_t    push_data, pop_data;
    logic             push, full, pop_valid, pop;

    assign vtx.pos_x = s_tdata[31:0];
    assign vtx.pos_y = s_tdata[63:32];
    assign vtx.pos_z = s_tdata[95:64];
    assign vtx.tex_u = s_tdata[127:96];
    assign vtx.tex_v = s_tdata[159:128];

    ttv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_vtx     (vtx),
        .push       (push),
        .push_data  (push_data),
        .queue_full (full)
    );

    ttv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    ttv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_pop   (pop),
        .job       (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 48'd0)
        else $error("degenerate result carries nonzero tangent");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[15:0]) >= -16'sd16384 &&
                     $signed(m_tdata[15:0]) <= 16'sd16384 &&
                     $signed(m_tdata[31:16]) >= -16'sd16384 &&
                     $signed(m_tdata[31:16]) <= 16'sd16384 &&
                     $signed(m_tdata[47:32]) >= -16'sd16384 &&
                     $signed(m_tdata[47:32]) <= 16'sd16384)
        else $error("tangent component out of unit range");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("job pushed into full queue");

endmodule
`default_nettype wire
